// File: design/pnv_pkg.sv
// Shared types, constants and helper functions for the next-vertex pipeline.
// Used by every cell, the chain module and the top level; depends on nothing.
`timescale 1ns / 1ps

package pnv_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ROT_STAGES = 20;
  localparam int DIV_NW     = 50;  // dividend bits, one quotient bit per cell
  localparam int DIV_DW     = 48;  // divisor bits
  localparam int DIV_CELLS  = DIV_NW;
  localparam int SQ_CELLS   = 32;  // two radicand bits per cell

  // ceil(2^39 / 315): exact floor division by 315 for dividends below 2^30
  localparam logic [30:0] ANG_RECIP = 31'd1745256553;
  localparam int          ANG_SHIFT = 39;

  localparam logic [1:0] MODE_SIDE   = 2'd0;
  localparam logic [1:0] MODE_DIAG   = 2'd1;
  localparam logic [1:0] MODE_BAD    = 2'd2;
  localparam logic [1:0] MODE_BAD_HI = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_DGN = 2'd2;

  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  // Item context carried alongside the arithmetic through every cell.
  typedef struct packed {
    logic               bad;
    logic               dgn;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [30:0]        len;
    logic               back;
    logic signed [25:0] ang;
    logic signed [31:0] m;
    logic signed [31:0] t;
    logic signed [31:0] m2;
    logic               qneg;
  } ctx_t;

  typedef struct packed {
    ctx_t                ctx;
    logic [DIV_NW-1:0]   num;
    logic [DIV_DW-1:0]   rem;
    logic [DIV_NW-1:0]   quo;
    logic [DIV_DW-1:0]   dvs;
  } div_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [33:0] base;
    logic [29:0] n;
  } ang_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [33:0] base;
    logic [60:0] prod;
  } angp_t;

  typedef struct packed {
    ctx_t               ctx;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [33:0] r;
  } cor_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [63:0] v;
    logic [35:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    ctx_t               ctx;
    logic signed [63:0] prod;
  } prd_t;

  typedef struct packed {
    ctx_t               ctx;
    logic signed [33:0] x2;
    logic signed [64:0] py;
  } fin_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] a;
    case (idx)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837830;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021688;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      5'd24: a = 34'sd64;
      5'd25: a = 34'sd32;
      5'd26: a = 34'sd16;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

  // Signed quotient from magnitude and sign fits in 32 bits.
  function automatic logic fits_s32(input logic [DIV_NW-1:0] mag, input logic neg);
    logic ok;
    ok = neg ? (mag <= DIV_NW'(64'd2147483648)) : (mag <= DIV_NW'(64'd2147483647));
    return ok;
  endfunction

  function automatic logic signed [31:0] to_s32(input logic [DIV_NW-1:0] mag,
                                                input logic neg);
    logic [31:0] v;
    v = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
    return $signed(v);
  endfunction

endpackage

// File: design/pnv_div_cell.sv
// One restoring-division cell: retires one quotient bit per beat.
// Depends on pnv_pkg for the division record type.
`timescale 1ns / 1ps

module pnv_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  pnv_pkg::div_t  d_in,
  output logic           vld_out,
  output pnv_pkg::div_t  d_out
);

  logic [pnv_pkg::DIV_DW:0] rem_sh;
  logic [pnv_pkg::DIV_DW:0] diff;
  logic                     ge;
  pnv_pkg::div_t            stage_nxt;
  pnv_pkg::div_t            stage_r;
  logic                     vld_r;

  always_comb begin
    stage_nxt = d_in;
    rem_sh    = {d_in.rem, d_in.num[pnv_pkg::DIV_NW-1]};
    diff      = rem_sh - {1'b0, d_in.dvs};
    ge        = (rem_sh >= {1'b0, d_in.dvs});
    stage_nxt.rem = ge ? diff[pnv_pkg::DIV_DW-1:0] : rem_sh[pnv_pkg::DIV_DW-1:0];
    stage_nxt.quo = {d_in.quo[pnv_pkg::DIV_NW-2:0], ge};
    stage_nxt.num = {d_in.num[pnv_pkg::DIV_NW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = stage_r;

endmodule

// File: design/pnv_div_chain.sv
// Row of DIV_CELLS division cells giving a full unsigned quotient.
// Depends on pnv_pkg and pnv_div_cell.
`timescale 1ns / 1ps

module pnv_div_chain (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  pnv_pkg::div_t  d_in,
  output logic           vld_out,
  output pnv_pkg::div_t  d_out
);

  logic          vld [0:pnv_pkg::DIV_CELLS];
  pnv_pkg::div_t dat [0:pnv_pkg::DIV_CELLS];

  assign vld[0] = vld_in;
  assign dat[0] = d_in;

  for (genvar i = 0; i < pnv_pkg::DIV_CELLS; i++) begin : g_cell
    pnv_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld[i]),
      .d_in    (dat[i]),
      .vld_out (vld[i+1]),
      .d_out   (dat[i+1])
    );
  end

  assign vld_out = vld[pnv_pkg::DIV_CELLS];
  assign d_out   = dat[pnv_pkg::DIV_CELLS];

endmodule

// File: design/pnv_cordic_cell.sv
// One rotation-mode CORDIC cell in Q30; the stage index picks shift and arctangent.
// Depends on pnv_pkg for the record type and the arctangent table.
`timescale 1ns / 1ps

module pnv_cordic_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [4:0]     stage_idx,
  input  logic           vld_in,
  input  pnv_pkg::cor_t  c_in,
  output logic           vld_out,
  output pnv_pkg::cor_t  c_out
);

  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [33:0] at;
  pnv_pkg::cor_t      stage_nxt;
  pnv_pkg::cor_t      stage_r;
  logic               vld_r;

  always_comb begin
    stage_nxt = c_in;
    xs = c_in.x >>> stage_idx;
    ys = c_in.y >>> stage_idx;
    at = pnv_pkg::atan_q30(stage_idx);
    if (!c_in.r[33]) begin
      stage_nxt.x = c_in.x - ys;
      stage_nxt.y = c_in.y + xs;
      stage_nxt.r = c_in.r - at;
    end else begin
      stage_nxt.x = c_in.x + ys;
      stage_nxt.y = c_in.y - xs;
      stage_nxt.r = c_in.r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign vld_out = vld_r;
  assign c_out   = stage_r;

endmodule

// File: design/pnv_sqrt_cell.sv
// One digit-by-digit square root cell: takes two radicand bits, yields one root bit.
// Depends on pnv_pkg for the root record type.
`timescale 1ns / 1ps

module pnv_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  pnv_pkg::sq_t  s_in,
  output logic          vld_out,
  output pnv_pkg::sq_t  s_out
);

  logic [35:0]  rem_sh;
  logic [35:0]  trial;
  logic         ge;
  pnv_pkg::sq_t stage_nxt;
  pnv_pkg::sq_t stage_r;
  logic         vld_r;

  always_comb begin
    stage_nxt = s_in;
    rem_sh = {s_in.rem[33:0], s_in.v[63:62]};
    trial  = {2'b00, s_in.root, 2'b01};
    ge     = (rem_sh >= trial);
    stage_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
    stage_nxt.root = {s_in.root[30:0], ge};
    stage_nxt.v    = {s_in.v[61:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign vld_out = vld_r;
  assign s_out   = stage_r;

endmodule

// File: design/polygon_next_vertex_from_turn.sv
// Next polygon vertex from a segment and a turn angle: glue stages around cell rows.
// Depends on pnv_pkg, pnv_div_chain, pnv_cordic_cell and pnv_sqrt_cell.
//
// Usage:
//   Input beats arrive on in_tvalid/in_tready with the segment, turn angle,
//   step length and direction flag in in_tdata and the anchor mode in in_tuser.
//   Each input beat gives exactly one output beat on out_tvalid/out_tready:
//   anchor point and computed end point in out_tdata, status in out_tuser.
//   The datapath is a fixed pipeline of cell rows: four restoring dividers of
//   50 cells each (slope, tangent, turned slope, step), a 20-cell CORDIC row
//   and a 32-cell square root row, joined by short glue stages; degrees turn
//   into radians by a reciprocal multiplication. The datapath holds 264 register
//   stages from the input beat to out_tvalid. One beat is taken per cycle, set by
//   the one-bit-per-cell rows, while the output side does not stall the pipeline.
//   Reset (rst_n low, synchronous) clears every valid bit; no beat is lost or
//   made up. When the receiver stalls, the output register holds its beat and
//   the pipeline keeps moving until a valid beat reaches its last stage, so
//   in_tready drops only once the pipeline tail is full behind a held result.
`timescale 1ns / 1ps

module polygon_next_vertex_from_turn (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x[31:0] start_y[63:32] end_x[95:64] end_y[127:96] turn_angle[153:128]
  // step_length[184:154] backward[185], zero fill above
  input  logic [191:0] in_tdata,
  // anchor_mode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_start_x[31:0] new_start_y[63:32] new_end_x[95:64] new_end_y[127:96]
  output logic [127:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser
);

  logic out_free;
  logic pipe_en;

  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic signed [32:0] ddx, ddy;
  logic [32:0]        ddx_a, ddy_a;
  logic [1:0]         mode;

  // glue registers
  logic g0_vld_r, g1_vld_r, ga_vld_r, g2_vld_r, g3_vld_r, g4_vld_r, g5_vld_r;
  logic g6_vld_r, g7_vld_r, g8_vld_r, g9_vld_r, out_vld_r;
  pnv_pkg::div_t  g0_r, g0_nxt, g3_r, g3_nxt, g5_r, g5_nxt, g8_r, g8_nxt;
  pnv_pkg::ang_t  g1_r, g1_nxt;
  pnv_pkg::angp_t ga_r, ga_nxt;
  pnv_pkg::cor_t  g2_r, g2_nxt;
  pnv_pkg::prd_t  g4_r, g4_nxt, g6_r, g6_nxt;
  pnv_pkg::sq_t   g7_r, g7_nxt;
  pnv_pkg::fin_t  g9_r, g9_nxt;
  logic [127:0]   out_data_r, out_data_nxt;
  logic [1:0]     out_user_r, out_user_nxt;

  // row outputs
  logic          d1_vld, d3_vld, d4_vld, d5_vld;
  pnv_pkg::div_t d1_o, d3_o, d4_o, d5_o;

  logic          co_vld [0:pnv_pkg::ROT_STAGES];
  pnv_pkg::cor_t co_dat [0:pnv_pkg::ROT_STAGES];
  logic          sq_vld [0:pnv_pkg::SQ_CELLS];
  pnv_pkg::sq_t  sq_dat [0:pnv_pkg::SQ_CELLS];

  // scratch for glue logic
  logic [25:0]        amag;
  logic [33:0]        rq, rm1, rm2;
  logic signed [33:0] rs;
  logic [32:0]        cy_a, cx_a;
  logic               t_ok, m2_ok;
  logic signed [63:0] sh, den, den_a;
  logic signed [32:0] tm_s;
  logic [32:0]        tm_a;
  logic [31:0]        m2_a;
  logic [30:0]        dxu;
  logic signed [32:0] dxs;
  logic signed [49:0] y2;
  logic signed [31:0] x2_sat, y2_sat;
  logic               ovf;

  assign out_free  = !out_vld_r || out_tready;
  assign pipe_en   = out_free || !g9_vld_r;
  assign in_tready = pipe_en;

  // ---------------- g0: unpack, anchor, slope division setup
  always_comb begin
    start_x = $signed(in_tdata[31:0]);
    start_y = $signed(in_tdata[63:32]);
    end_x   = $signed(in_tdata[95:64]);
    end_y   = $signed(in_tdata[127:96]);
    mode    = in_tuser;
    ddx     = 33'(end_x) - 33'(start_x);
    ddy     = 33'(end_y) - 33'(start_y);
    ddx_a   = ddx[32] ? 33'(-ddx) : 33'(ddx);
    ddy_a   = ddy[32] ? 33'(-ddy) : 33'(ddy);
    g0_nxt          = '0;
    g0_nxt.ctx.bad  = !(mode == pnv_pkg::MODE_SIDE || mode == pnv_pkg::MODE_DIAG);
    g0_nxt.ctx.dgn  = (ddx == 33'sd0);
    g0_nxt.ctx.ax   = (mode == pnv_pkg::MODE_SIDE) ? end_x : start_x;
    g0_nxt.ctx.ay   = (mode == pnv_pkg::MODE_SIDE) ? end_y : start_y;
    g0_nxt.ctx.ang  = $signed(in_tdata[153:128]);
    g0_nxt.ctx.len  = in_tdata[184:154];
    g0_nxt.ctx.back = in_tdata[185];
    g0_nxt.ctx.qneg = ddx[32] ^ ddy[32];
    g0_nxt.num      = pnv_pkg::DIV_NW'(ddy_a) << pnv_pkg::FRAC_BITS;
    g0_nxt.dvs      = pnv_pkg::DIV_DW'(ddx_a);
  end

  pnv_div_chain u_div_m (
    .clk (clk), .rst_n (rst_n), .en (pipe_en),
    .vld_in (g0_vld_r), .d_in (g0_r), .vld_out (d1_vld), .d_out (d1_o)
  );

  // ---------------- g1: slope out, degrees to Q30 radians setup
  always_comb begin
    g1_nxt         = '0;
    g1_nxt.ctx     = d1_o.ctx;
    g1_nxt.ctx.m   = pnv_pkg::to_s32(d1_o.quo, d1_o.ctx.qneg);
    g1_nxt.ctx.dgn = d1_o.ctx.dgn || !pnv_pkg::fits_s32(d1_o.quo, d1_o.ctx.qneg);
    amag = d1_o.ctx.ang[25] ? 26'(-d1_o.ctx.ang) : 26'(d1_o.ctx.ang);
    g1_nxt.ctx.qneg = d1_o.ctx.ang[25];
    // round(a*11*2^14/630) splits into 286*a + floor((22*a + 157)/315)
    g1_nxt.base = 34'(amag) * 34'd286;
    g1_nxt.n    = 30'(amag) * 30'd22 + 30'd157;
  end

  // ---------------- ga: reciprocal product for the division by 315
  always_comb begin
    ga_nxt      = '0;
    ga_nxt.ctx  = g1_r.ctx;
    ga_nxt.base = g1_r.base;
    ga_nxt.prod = 61'(g1_r.n) * 61'(pnv_pkg::ANG_RECIP);
  end

  // ---------------- g2: reduce into [-pi/2, pi/2], start rotation
  always_comb begin
    rq  = ga_r.base + 34'(ga_r.prod >> pnv_pkg::ANG_SHIFT);
    rm1 = (rq  >= 34'(pnv_pkg::PI_Q30)) ? (rq  - 34'(pnv_pkg::PI_Q30)) : rq;
    rm2 = (rm1 >= 34'(pnv_pkg::PI_Q30)) ? (rm1 - 34'(pnv_pkg::PI_Q30)) : rm1;
    rs  = ga_r.ctx.qneg ? -$signed(rm2) : $signed(rm2);
    g2_nxt     = '0;
    g2_nxt.ctx = ga_r.ctx;
    g2_nxt.x   = 33'sd1073741824;
    g2_nxt.y   = 33'sd0;
    if (rs > pnv_pkg::HALF_PI_Q30) begin
      g2_nxt.r = rs - pnv_pkg::PI_Q30;
    end else if (rs < -pnv_pkg::HALF_PI_Q30) begin
      g2_nxt.r = rs + pnv_pkg::PI_Q30;
    end else begin
      g2_nxt.r = rs;
    end
  end

  assign co_vld[0] = g2_vld_r;
  assign co_dat[0] = g2_r;

  for (genvar i = 0; i < pnv_pkg::ROT_STAGES; i++) begin : g_rot
    pnv_cordic_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (pipe_en), .stage_idx (5'(i)),
      .vld_in (co_vld[i]), .c_in (co_dat[i]),
      .vld_out (co_vld[i+1]), .c_out (co_dat[i+1])
    );
  end

  // ---------------- g3: tangent division setup
  always_comb begin
    cy_a = co_dat[pnv_pkg::ROT_STAGES].y[32] ? 33'(-co_dat[pnv_pkg::ROT_STAGES].y)
                                             : 33'(co_dat[pnv_pkg::ROT_STAGES].y);
    cx_a = co_dat[pnv_pkg::ROT_STAGES].x[32] ? 33'(-co_dat[pnv_pkg::ROT_STAGES].x)
                                             : 33'(co_dat[pnv_pkg::ROT_STAGES].x);
    g3_nxt          = '0;
    g3_nxt.ctx      = co_dat[pnv_pkg::ROT_STAGES].ctx;
    g3_nxt.ctx.dgn  = co_dat[pnv_pkg::ROT_STAGES].ctx.dgn
                      || (co_dat[pnv_pkg::ROT_STAGES].x == 33'sd0);
    g3_nxt.ctx.qneg = co_dat[pnv_pkg::ROT_STAGES].x[32] ^ co_dat[pnv_pkg::ROT_STAGES].y[32];
    g3_nxt.num      = pnv_pkg::DIV_NW'(cy_a) << pnv_pkg::FRAC_BITS;
    g3_nxt.dvs      = pnv_pkg::DIV_DW'(cx_a);
  end

  pnv_div_chain u_div_t (
    .clk (clk), .rst_n (rst_n), .en (pipe_en),
    .vld_in (g3_vld_r), .d_in (g3_r), .vld_out (d3_vld), .d_out (d3_o)
  );

  // ---------------- g4: tangent out, t*m product
  always_comb begin
    t_ok           = pnv_pkg::fits_s32(d3_o.quo, d3_o.ctx.qneg);
    g4_nxt.ctx     = d3_o.ctx;
    g4_nxt.ctx.t   = pnv_pkg::to_s32(d3_o.quo, d3_o.ctx.qneg);
    g4_nxt.ctx.dgn = d3_o.ctx.dgn || !t_ok;
    g4_nxt.prod    = g4_nxt.ctx.t * g4_nxt.ctx.m;
  end

  // ---------------- g5: turned slope division setup
  always_comb begin
    sh    = g4_r.prod >>> pnv_pkg::FRAC_BITS;
    den   = (64'sd1 <<< pnv_pkg::FRAC_BITS) - sh;
    den_a = den[63] ? -den : den;
    tm_s  = 33'(g4_r.ctx.t) + 33'(g4_r.ctx.m);
    tm_a  = tm_s[32] ? 33'(-tm_s) : 33'(tm_s);
    g5_nxt          = '0;
    g5_nxt.ctx      = g4_r.ctx;
    g5_nxt.ctx.dgn  = g4_r.ctx.dgn || (den == 64'sd0);
    g5_nxt.ctx.qneg = tm_s[32] ^ den[63];
    g5_nxt.num      = pnv_pkg::DIV_NW'(tm_a) << pnv_pkg::FRAC_BITS;
    g5_nxt.dvs      = den_a[pnv_pkg::DIV_DW-1:0];
  end

  pnv_div_chain u_div_m2 (
    .clk (clk), .rst_n (rst_n), .en (pipe_en),
    .vld_in (g5_vld_r), .d_in (g5_r), .vld_out (d4_vld), .d_out (d4_o)
  );

  // ---------------- g6: turned slope out, square it
  always_comb begin
    m2_ok          = pnv_pkg::fits_s32(d4_o.quo, d4_o.ctx.qneg);
    g6_nxt.ctx     = d4_o.ctx;
    g6_nxt.ctx.m2  = pnv_pkg::to_s32(d4_o.quo, d4_o.ctx.qneg);
    g6_nxt.ctx.dgn = d4_o.ctx.dgn || !m2_ok;
    m2_a           = g6_nxt.ctx.m2[31] ? 32'(-g6_nxt.ctx.m2) : 32'(g6_nxt.ctx.m2);
    g6_nxt.prod    = $signed(64'(m2_a) * 64'(m2_a));
  end

  // ---------------- g7: radicand 1 + m2^2 in Q32
  always_comb begin
    g7_nxt      = '0;
    g7_nxt.ctx  = g6_r.ctx;
    g7_nxt.v    = (64'd1 << (2 * pnv_pkg::FRAC_BITS)) + 64'(g6_r.prod);
  end

  assign sq_vld[0] = g7_vld_r;
  assign sq_dat[0] = g7_r;

  for (genvar i = 0; i < pnv_pkg::SQ_CELLS; i++) begin : g_sq
    pnv_sqrt_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (pipe_en),
      .vld_in (sq_vld[i]), .s_in (sq_dat[i]),
      .vld_out (sq_vld[i+1]), .s_out (sq_dat[i+1])
    );
  end

  // ---------------- g8: horizontal step division setup
  always_comb begin
    g8_nxt          = '0;
    g8_nxt.ctx      = sq_dat[pnv_pkg::SQ_CELLS].ctx;
    g8_nxt.ctx.qneg = 1'b0;
    g8_nxt.num      = pnv_pkg::DIV_NW'(sq_dat[pnv_pkg::SQ_CELLS].ctx.len)
                      << pnv_pkg::FRAC_BITS;
    g8_nxt.dvs      = pnv_pkg::DIV_DW'(sq_dat[pnv_pkg::SQ_CELLS].root);
  end

  pnv_div_chain u_div_dx (
    .clk (clk), .rst_n (rst_n), .en (pipe_en),
    .vld_in (g8_vld_r), .d_in (g8_r), .vld_out (d5_vld), .d_out (d5_o)
  );

  // ---------------- g9: signed step, end x, rise product
  always_comb begin
    dxu        = d5_o.quo[30:0];
    dxs        = d5_o.ctx.back ? -$signed({2'b00, dxu}) : $signed({2'b00, dxu});
    g9_nxt.ctx = d5_o.ctx;
    g9_nxt.x2  = 34'(d5_o.ctx.ax) + 34'(dxs);
    g9_nxt.py  = d5_o.ctx.m2 * dxs;
  end

  // ---------------- output stage: saturate, mask special cases
  always_comb begin
    y2     = 50'(g9_r.ctx.ay) + 50'(g9_r.py >>> pnv_pkg::FRAC_BITS);
    ovf    = 1'b0;
    x2_sat = g9_r.x2[31:0];
    y2_sat = y2[31:0];
    if (g9_r.x2 > 34'sd2147483647) begin
      x2_sat = 32'sh7fffffff;
      ovf    = 1'b1;
    end else if (g9_r.x2 < -34'sd2147483648) begin
      x2_sat = 32'sh80000000;
      ovf    = 1'b1;
    end
    if (y2 > 50'sd2147483647) begin
      y2_sat = 32'sh7fffffff;
      ovf    = 1'b1;
    end else if (y2 < -50'sd2147483648) begin
      y2_sat = 32'sh80000000;
      ovf    = 1'b1;
    end
    if (g9_r.ctx.bad) begin
      out_data_nxt = '0;
      out_user_nxt = pnv_pkg::ST_BAD;
    end else if (g9_r.ctx.dgn) begin
      out_data_nxt = {64'd0, g9_r.ctx.ay, g9_r.ctx.ax};
      out_user_nxt = pnv_pkg::ST_DGN;
    end else begin
      out_data_nxt = {y2_sat, x2_sat, g9_r.ctx.ay, g9_r.ctx.ax};
      out_user_nxt = ovf ? pnv_pkg::ST_DGN : pnv_pkg::ST_OK;
    end
  end

  // valids: advance with the pipeline, output slot only when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g0_vld_r  <= 1'b0;
      g1_vld_r  <= 1'b0;
      ga_vld_r  <= 1'b0;
      g2_vld_r  <= 1'b0;
      g3_vld_r  <= 1'b0;
      g4_vld_r  <= 1'b0;
      g5_vld_r  <= 1'b0;
      g6_vld_r  <= 1'b0;
      g7_vld_r  <= 1'b0;
      g8_vld_r  <= 1'b0;
      g9_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (pipe_en) begin
        g0_vld_r <= in_tvalid;
        g1_vld_r <= d1_vld;
        ga_vld_r <= g1_vld_r;
        g2_vld_r <= ga_vld_r;
        g3_vld_r <= co_vld[pnv_pkg::ROT_STAGES];
        g4_vld_r <= d3_vld;
        g5_vld_r <= g4_vld_r;
        g6_vld_r <= d4_vld;
        g7_vld_r <= g6_vld_r;
        g8_vld_r <= sq_vld[pnv_pkg::SQ_CELLS];
        g9_vld_r <= d5_vld;
      end
      if (out_free) begin
        out_vld_r <= g9_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      g0_r <= g0_nxt;
      g1_r <= g1_nxt;
      ga_r <= ga_nxt;
      g2_r <= g2_nxt;
      g3_r <= g3_nxt;
      g4_r <= g4_nxt;
      g5_r <= g5_nxt;
      g6_r <= g6_nxt;
      g7_r <= g7_nxt;
      g8_r <= g8_nxt;
      g9_r <= g9_nxt;
    end
    if (out_free) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: design/pnv_checker.sv
// Port-level checks for the next-vertex block, bound onto the top level.
// Depends on pnv_pkg for status codes and on polygon_next_vertex_from_turn.
`timescale 1ns / 1ps

module pnv_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [191:0] in_tdata,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // a bad mode beat carries no coordinates
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pnv_pkg::ST_BAD |-> out_tdata == '0)
    else $error("bad mode beat with nonzero data");

  // an empty output slot never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind polygon_next_vertex_from_turn pnv_checker u_pnv_checker (.*);

// File: verif/pnv_checker.sv
// Checker for the next-vertex block: watches both stream channels, predicts each result
// from the accepted input beat and compares field by field. Depends on pnv_pkg.
`timescale 1ns / 1ps

module pnv_tb_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           pending_count
);

  typedef struct {
    logic [31:0] sx, sy, ex, ey;
    logic [1:0]  st;
  } vertex_t;

  vertex_t vertex_q[$];

  localparam longint ONE_Q = 64'sd1 << pnv_pkg::FRAC_BITS;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic bit fits(longint v);
    return v >= -64'sd2147483648 && v <= 64'sd2147483647;
  endfunction

  function automatic longint sat(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin ovf = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin ovf = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit turn_tangent(longint ang, output longint tq);
    longint n, mag, r, x, y, xs, ys;
    n = ang * 11 * (64'sd1 << (30 - pnv_pkg::FRAC_BITS));
    mag = n < 0 ? -n : n;
    r = (mag + 315) / 630;
    tq = 0;
    if (n < 0) r = -r;
    r = r % longint'(pnv_pkg::PI_Q30);
    if (r > longint'(pnv_pkg::HALF_PI_Q30)) r -= longint'(pnv_pkg::PI_Q30);
    if (r < -longint'(pnv_pkg::HALF_PI_Q30)) r += longint'(pnv_pkg::PI_Q30);
    x = 64'sd1 << 30;
    y = 0;
    for (int i = 0; i < pnv_pkg::ROT_STAGES && i < 32; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (r >= 0) begin
        x -= ys; y += xs; r -= longint'(pnv_pkg::atan_q30(5'(i)));
      end else begin
        x += ys; y -= xs; r += longint'(pnv_pkg::atan_q30(5'(i)));
      end
    end
    if (x == 0) return 0;
    tq = (y * ONE_Q) / x;
    return fits(tq);
  endfunction

  function automatic vertex_t next_vertex(logic [191:0] d, logic [1:0] mode);
    vertex_t v;
    longint sxp, syp, exq, eyq, ang, ax, ay, ddx, ddy, m, t, den, m2, dxs, x2, y2;
    longint unsigned len, m2a, dd, dxu;
    bit ovf;
    sxp = longint'($signed(d[31:0]));
    syp = longint'($signed(d[63:32]));
    exq = longint'($signed(d[95:64]));
    eyq = longint'($signed(d[127:96]));
    ang = longint'($signed(d[153:128]));
    len = longint'(d[184:154]);
    ovf = 0;
    v = '{0, 0, 0, 0, pnv_pkg::ST_BAD};
    if (mode != pnv_pkg::MODE_SIDE && mode != pnv_pkg::MODE_DIAG) return v;
    ax = mode == pnv_pkg::MODE_SIDE ? exq : sxp;
    ay = mode == pnv_pkg::MODE_SIDE ? eyq : syp;
    v.sx = ax[31:0];
    v.sy = ay[31:0];
    v.st = pnv_pkg::ST_DGN;
    ddx = exq - sxp;
    ddy = eyq - syp;
    if (ddx == 0) return v;
    m = (ddy * ONE_Q) / ddx;
    if (!fits(m)) return v;
    if (!turn_tangent(ang, t)) return v;
    den = ONE_Q - fshr(t * m, pnv_pkg::FRAC_BITS);
    if (den == 0) return v;
    m2 = ((t + m) * ONE_Q) / den;
    if (!fits(m2)) return v;
    m2a = m2 < 0 ? -m2 : m2;
    dd = root64((64'd1 << (2 * pnv_pkg::FRAC_BITS)) + m2a * m2a);
    dxu = (len * ONE_Q) / dd;
    dxs = d[185] ? -longint'(dxu) : longint'(dxu);
    x2 = sat(ax + dxs, ovf);
    y2 = sat(ay + fshr(m2 * dxs, pnv_pkg::FRAC_BITS), ovf);
    v.ex = x2[31:0];
    v.ey = y2[31:0];
    v.st = ovf ? pnv_pkg::ST_DGN : pnv_pkg::ST_OK;
    return v;
  endfunction

  assign pending_count = vertex_q.size();

  always @(posedge clk) begin
    vertex_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) vertex_q.push_back(next_vertex(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (vertex_q.size() == 0) begin
          $error("unexpected output beat");
          fail_count <= fail_count + 1;
        end else begin
          want = vertex_q.pop_front();
          if (out_tdata[31:0] !== want.sx || out_tdata[63:32] !== want.sy ||
              out_tdata[95:64] !== want.ex || out_tdata[127:96] !== want.ey ||
              out_tuser !== want.st)
            fail_count <= fail_count + 1;
          if (out_tdata[31:0] !== want.sx)
            $error("new_start_x exp %h got %h", want.sx, out_tdata[31:0]);
          if (out_tdata[63:32] !== want.sy)
            $error("new_start_y exp %h got %h", want.sy, out_tdata[63:32]);
          if (out_tdata[95:64] !== want.ex)
            $error("new_end_x exp %h got %h", want.ex, out_tdata[95:64]);
          if (out_tdata[127:96] !== want.ey)
            $error("new_end_y exp %h got %h", want.ey, out_tdata[127:96]);
          if (out_tuser !== want.st)
            $error("status exp %0d got %0d", want.st, out_tuser);
        end
      end
    end
  end
endmodule

// File: verif/tb_top.sv
// Top of the next-vertex testbench: clock, reset, directed and random stimulus, verdict.
// Depends on pnv_pkg, pnv_tb_checker and polygon_next_vertex_from_turn.
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = 264;
  localparam int CYCLE_LIMIT = 200000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count, pending_count;
  int           cycle_count = 0;
  int           send_idle = 0, recv_idle = 0;

  always #5 clk = ~clk;

  polygon_next_vertex_from_turn DUT (.*);

  pnv_tb_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [191:0] pack_item(logic [31:0] sx, sy, ex, ey, logic [25:0] ang,
                                            logic [30:0] len, logic bk);
    return {6'd0, bk, len, ang, ey, ex, sy, sx};
  endfunction

  // hold valid across the handshake edge; drop it only while idling
  task automatic send_beat(logic [191:0] d, logic [1:0] mode);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    in_tuser <= mode;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [25:0] rand_angle();
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return 26'($signed($urandom_range(720)) - 360) <<< 16;
    return 26'($signed($urandom_range(47185920)) - 23592960);
  endfunction

  task automatic random_item();
    logic [31:0] sx, sy, ex, ey;
    logic [30:0] len;
    logic [1:0]  mode;
    int sel;
    sel = $urandom_range(9);
    sx = $urandom; sy = $urandom;
    if (sel < 7) begin
      // moderate coordinates so most beats reach the end point math
      sx = 32'($signed($urandom_range(200 << 16)) - (100 << 16));
      sy = 32'($signed($urandom_range(200 << 16)) - (100 << 16));
      ex = sx + 32'($signed($urandom_range(40 << 16)) - (20 << 16));
      ey = sy + 32'($signed($urandom_range(40 << 16)) - (20 << 16));
      len = 31'($urandom_range(50 << 16));
    end else begin
      ex = (sel == 7) ? sx : $urandom;
      ey = $urandom;
      len = 31'($urandom);
    end
    mode = ($urandom_range(19) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
    send_beat(pack_item(sx, sy, ex, ey, rand_angle(), len, 1'($urandom)), mode);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_idle = 8;
    recv_idle = 88;
    // directed: extremes, both modes, bad modes, vertical, singular, overflow
    send_beat(pack_item(0, 0, 1 << 16, 0, '0, 31'(1 << 16), 1'b0), pnv_pkg::MODE_SIDE);
    send_beat(pack_item(0, 0, 1 << 16, 1 << 16, 26'(90 << 16), 31'(2 << 16), 1'b1),
              pnv_pkg::MODE_DIAG);
    send_beat(pack_item(0, 0, 1 << 16, 1 << 16, 26'(45 << 16), 31'(1 << 16), 1'b0),
              pnv_pkg::MODE_SIDE);
    send_beat(pack_item(5, 6, 7, 8, '0, 31'd1, 1'b0), pnv_pkg::MODE_BAD);
    send_beat(pack_item('1, '1, '1, '1, '1, '1, 1'b1), pnv_pkg::MODE_BAD_HI);
    send_beat(pack_item(3 << 16, 0, 3 << 16, 9 << 16, '0, 31'(1 << 16), 1'b0),
              pnv_pkg::MODE_SIDE);
    send_beat(pack_item(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, '0, '0, 1'b0),
              pnv_pkg::MODE_DIAG);
    send_beat(pack_item(0, 0, 1, 32'h7fffffff, '0, 31'(1 << 16), 1'b0), pnv_pkg::MODE_SIDE);
    send_beat(pack_item(0, 0, 1 << 16, 0, 26'sd23592960, 31'(1 << 16), 1'b0),
              pnv_pkg::MODE_SIDE);
    send_beat(pack_item(0, 0, 1 << 16, 0, -26'sd23592960, 31'(1 << 16), 1'b1),
              pnv_pkg::MODE_DIAG);
    send_beat(pack_item(0, 0, 1 << 16, 0, 26'(180 << 16), 31'(1 << 16), 1'b0),
              pnv_pkg::MODE_SIDE);
    send_beat(pack_item(0, 0, 1 << 16, 0, 26'(-(90 << 16)), 31'(1 << 16), 1'b0),
              pnv_pkg::MODE_SIDE);
    send_beat(pack_item(32'h7fff0000, 0, 32'h7fff8000, 0, '0, 31'h7fffffff, 1'b0),
              pnv_pkg::MODE_SIDE);
    send_beat(pack_item(32'h80008000, 32'h80000000, 32'h80000000, 32'h80000000, '0,
                        31'h7fffffff, 1'b1), pnv_pkg::MODE_SIDE);
    send_beat(pack_item(0, 32'h7fff0000, 1 << 16, 32'h7fff0000, 26'(45 << 16),
                        31'h7fffffff, 1'b0), pnv_pkg::MODE_SIDE);
    send_beat(pack_item(32'hffff0000, 32'hffff0000, 32'h00010000, 32'h00010000,
                        26'(135 << 16), 31'(3 << 16), 1'b1), pnv_pkg::MODE_SIDE);
    for (int i = 0; i < 400; i++) random_item();
    send_idle = 88;
    recv_idle = 8;
    for (int i = 0; i < 350; i++) random_item();
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 400; i++) random_item();
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: filelist.f
design/pnv_pkg.sv
design/pnv_div_cell.sv
design/pnv_div_chain.sv
design/pnv_cordic_cell.sv
design/pnv_sqrt_cell.sv
design/polygon_next_vertex_from_turn.sv
design/pnv_checker.sv
verif/pnv_checker.sv
verif/tb_top.sv
